@@ hw/rtl/dgap_pkg.sv @@
// Shared constants, types and helper functions of the gap word packer.
package dgap_pkg;

    localparam int WORD_BITS    = 32;
    localparam int PAYLOAD_BITS = 28;
    localparam int CODE_BITS    = 4;
    localparam int BUF_DEPTH    = 32;
    localparam int BUF_AW       = 5;
    localparam int CNT_W        = 6;
    localparam int LEN_W        = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;
    localparam int QUEUE_CW     = 3;

    localparam logic [CODE_BITS-1:0] CODE_W28 = 4'd0;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] gap;
        logic                    list_end;
        logic                    too_wide;
    } gap_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] max_bits;
        logic [CNT_W-1:0] elems;
        logic             decided;
    } fold_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RESCAN_RD,
        BK_RESCAN_USE,
        BK_PAD,
        BK_PACK_RD,
        BK_PACK_USE,
        BK_OUT
    } back_state_t;

    function automatic logic [LEN_W-1:0] bit_len(logic [PAYLOAD_BITS-1:0] g);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < PAYLOAD_BITS; i++)
        begin
            if (g[i])
            begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    // One look-ahead step: zero gaps count as one bit.
    function automatic fold_t fold_gap(logic [LEN_W-1:0] max_bits,
                                       logic [CNT_W-1:0] elems,
                                       logic [PAYLOAD_BITS-1:0] g);
        logic [LEN_W-1:0]       b;
        logic [LEN_W+CNT_W-1:0] prod;
        fold_t                  r;
        b = bit_len(g);
        if (b == '0)
        begin
            b = LEN_W'(1);
        end
        r.max_bits = (b > max_bits) ? b : max_bits;
        r.elems    = elems + CNT_W'(1);
        prod       = (LEN_W+CNT_W)'(r.max_bits) * (LEN_W+CNT_W)'(r.elems);
        r.decided  = (prod >= (LEN_W+CNT_W)'(WORD_BITS));
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] width_of(logic [LEN_W-1:0] m);
        logic [LEN_W-1:0] w;
        if (m > LEN_W'(14))
        begin
            w = LEN_W'(28);
        end
        else if (m > LEN_W'(9))
        begin
            w = LEN_W'(14);
        end
        else if (m > LEN_W'(7))
        begin
            w = LEN_W'(9);
        end
        else if (m > LEN_W'(5))
        begin
            w = LEN_W'(7);
        end
        else
        begin
            w = m;
        end
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] gaps_per_word(logic [LEN_W-1:0] w);
        logic [LEN_W-1:0] n;
        case (w)
            LEN_W'(1):  n = LEN_W'(28);
            LEN_W'(2):  n = LEN_W'(14);
            LEN_W'(3):  n = LEN_W'(9);
            LEN_W'(4):  n = LEN_W'(7);
            LEN_W'(5):  n = LEN_W'(5);
            LEN_W'(7):  n = LEN_W'(4);
            LEN_W'(9):  n = LEN_W'(3);
            LEN_W'(14): n = LEN_W'(2);
            default:    n = LEN_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [CODE_BITS-1:0] width_code(logic [LEN_W-1:0] w);
        return (w == LEN_W'(PAYLOAD_BITS)) ? CODE_W28 : w[CODE_BITS-1:0];
    endfunction

endpackage

@@ hw/rtl/dgap_ifs.sv @@
// Channel interfaces: document numbers in, packed words out.
interface dgap_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] doc_number;
    logic        list_end;

    modport source (output valid, output doc_number, output list_end, input ready);
    modport sink   (input valid, input doc_number, input list_end, output ready);
endinterface

interface dgap_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;
    logic        last_word;
    logic        gap_too_wide;

    modport source (output valid, output packed_word, output last_word,
                    output gap_too_wide, input ready);
    modport sink   (input valid, input packed_word, input last_word,
                    input gap_too_wide, output ready);
endinterface

@@ hw/rtl/dgap_front.sv @@
// Front end: gap computation, too-wide check and list dropping.
module dgap_front (
    input  logic               clk,
    input  logic               rst_n,
    dgap_in_if.sink            docs,
    output logic               push_valid,
    input  logic               push_ready,
    output dgap_pkg::gap_item_t push_item
);

    logic [31:0] previous_doc_reg;
    logic [31:0] previous_doc_next;
    logic        dropping_reg;
    logic        dropping_next;
    logic        accept;
    logic [31:0] gap_full;
    logic        too_wide;

    assign docs.ready = push_ready;
    assign accept     = docs.valid && docs.ready;
    assign gap_full   = docs.doc_number - previous_doc_reg;
    assign too_wide   = |gap_full[31:dgap_pkg::PAYLOAD_BITS];

    assign push_valid         = docs.valid && !dropping_reg;
    assign push_item.gap      = gap_full[dgap_pkg::PAYLOAD_BITS-1:0];
    assign push_item.list_end = docs.list_end;
    assign push_item.too_wide = too_wide;

    always_comb
    begin
        previous_doc_next = previous_doc_reg;
        dropping_next     = dropping_reg;
        if (accept)
        begin
            if (dropping_reg)
            begin
                if (docs.list_end)
                begin
                    dropping_next     = 1'b0;
                    previous_doc_next = '0;
                end
            end
            else
            begin
                previous_doc_next = docs.list_end ? '0 : docs.doc_number;
                if (too_wide && !docs.list_end)
                begin
                    dropping_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_doc_reg <= '0;
            dropping_reg     <= 1'b0;
        end
        else
        begin
            previous_doc_reg <= previous_doc_next;
            dropping_reg     <= dropping_next;
        end
    end

endmodule

@@ hw/rtl/dgap_queue.sv @@
// Short item queue between front and back end.
module dgap_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  dgap_pkg::gap_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output dgap_pkg::gap_item_t pop_item
);

    dgap_pkg::gap_item_t               slot_reg [dgap_pkg::QUEUE_DEPTH];
    logic [dgap_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [dgap_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [dgap_pkg::QUEUE_CW-1:0]     fill_reg;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (fill_reg != dgap_pkg::QUEUE_CW'(dgap_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dgap_pkg::QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dgap_pkg::QUEUE_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + dgap_pkg::QUEUE_CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - dgap_pkg::QUEUE_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/dgap_back.sv @@
// Back end: gap buffer, width look-ahead, word packing and output register.
module dgap_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  dgap_pkg::gap_item_t pop_item,
    dgap_out_if.source          words
);

    localparam int AW = dgap_pkg::BUF_AW;
    localparam int CW = dgap_pkg::CNT_W;
    localparam int LW = dgap_pkg::LEN_W;
    localparam int PW = dgap_pkg::PAYLOAD_BITS;

    dgap_pkg::back_state_t state_reg, state_next;

    logic [PW-1:0] gap_mem [dgap_pkg::BUF_DEPTH];
    logic [PW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] tail_addr;
    logic          rd_en;
    logic          wr_en;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] scan_max_reg, scan_max_next;
    logic [CW-1:0] scan_elems_reg, scan_elems_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          flush_reg, flush_next;
    logic [LW-1:0] width_reg, width_next;
    logic [LW-1:0] nwords_reg, nwords_next;
    logic [LW-1:0] offset_reg, offset_next;
    logic [PW-1:0] payload_reg, payload_next;
    logic [31:0]   word_reg, word_next;
    logic          last_reg, last_next;
    logic          err_reg, err_next;

    logic [PW-1:0]   fold_in;
    dgap_pkg::fold_t fold_res;
    logic [LW-1:0]   new_width;
    logic            pack_start;
    logic            pop_take;
    logic [CW-1:0]   nwords_ext;
    logic [CW-1:0]   used;
    logic [CW-1:0]   remain;

    assign pop_ready  = (state_reg == dgap_pkg::BK_IDLE);
    assign pop_take   = pop_valid && pop_ready;
    assign tail_addr  = head_reg + count_reg[AW-1:0];
    assign rd_addr    = head_reg + idx_reg[AW-1:0];
    assign nwords_ext = {1'b0, nwords_reg};
    assign used       = (nwords_ext < count_reg) ? nwords_ext : count_reg;
    assign remain     = count_reg - used;

    always_comb
    begin
        case (state_reg)
            dgap_pkg::BK_IDLE:       fold_in = pop_item.gap;
            dgap_pkg::BK_RESCAN_USE: fold_in = rd_data_reg;
            default:                 fold_in = '0;
        endcase
    end

    assign fold_res  = dgap_pkg::fold_gap(scan_max_reg, scan_elems_reg, fold_in);
    assign new_width = dgap_pkg::width_of(fold_res.max_bits);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dgap_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_item.too_wide)
                    begin
                        state_next = dgap_pkg::BK_OUT;
                    end
                    else if (fold_res.decided)
                    begin
                        state_next = dgap_pkg::BK_PACK_RD;
                    end
                    else if (pop_item.list_end)
                    begin
                        state_next = dgap_pkg::BK_PAD;
                    end
                end
            end
            dgap_pkg::BK_RESCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = flush_reg ? dgap_pkg::BK_PAD : dgap_pkg::BK_IDLE;
                end
                else
                begin
                    state_next = dgap_pkg::BK_RESCAN_USE;
                end
            end
            dgap_pkg::BK_RESCAN_USE:
            begin
                state_next = fold_res.decided ? dgap_pkg::BK_PACK_RD
                                              : dgap_pkg::BK_RESCAN_RD;
            end
            dgap_pkg::BK_PAD:
            begin
                if (fold_res.decided)
                begin
                    state_next = dgap_pkg::BK_PACK_RD;
                end
            end
            dgap_pkg::BK_PACK_RD:
            begin
                if (idx_reg == nwords_ext)
                begin
                    state_next = dgap_pkg::BK_OUT;
                end
                else if (idx_reg < count_reg)
                begin
                    state_next = dgap_pkg::BK_PACK_USE;
                end
            end
            dgap_pkg::BK_PACK_USE:
            begin
                state_next = dgap_pkg::BK_PACK_RD;
            end
            dgap_pkg::BK_OUT:
            begin
                if (words.ready)
                begin
                    state_next = (last_reg || err_reg) ? dgap_pkg::BK_IDLE
                                                       : dgap_pkg::BK_RESCAN_RD;
                end
            end
            default:
            begin
                state_next = dgap_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        scan_max_next   = scan_max_reg;
        scan_elems_next = scan_elems_reg;
        idx_next        = idx_reg;
        flush_next      = flush_reg;
        width_next      = width_reg;
        nwords_next     = nwords_reg;
        offset_next     = offset_reg;
        payload_next    = payload_reg;
        word_next       = word_reg;
        last_next       = last_reg;
        err_next        = err_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        pack_start      = 1'b0;
        unique case (state_reg)
            dgap_pkg::BK_IDLE:
            begin
                if (pop_take)
                begin
                    if (pop_item.too_wide)
                    begin
                        word_next       = '0;
                        last_next       = 1'b1;
                        err_next        = 1'b1;
                        count_next      = '0;
                        scan_max_next   = '0;
                        scan_elems_next = '0;
                        flush_next      = 1'b0;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + CW'(1);
                        scan_max_next   = fold_res.max_bits;
                        scan_elems_next = fold_res.elems;
                        flush_next      = pop_item.list_end;
                        pack_start      = fold_res.decided;
                    end
                end
            end
            dgap_pkg::BK_RESCAN_RD:
            begin
                rd_en = (idx_reg != count_reg);
            end
            dgap_pkg::BK_RESCAN_USE:
            begin
                scan_max_next   = fold_res.max_bits;
                scan_elems_next = fold_res.elems;
                idx_next        = idx_reg + CW'(1);
                pack_start      = fold_res.decided;
            end
            dgap_pkg::BK_PAD:
            begin
                // look-ahead past the buffered gaps sees zeros
                scan_max_next   = fold_res.max_bits;
                scan_elems_next = fold_res.elems;
                pack_start      = fold_res.decided;
            end
            dgap_pkg::BK_PACK_RD:
            begin
                if (idx_reg == nwords_ext)
                begin
                    head_next       = head_reg + used[AW-1:0];
                    count_next      = remain;
                    word_next       = {payload_reg, dgap_pkg::width_code(width_reg)};
                    last_next       = flush_reg && (remain == '0);
                    err_next        = 1'b0;
                    scan_max_next   = '0;
                    scan_elems_next = '0;
                    idx_next        = '0;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    // zero padding slot
                    idx_next    = idx_reg + CW'(1);
                    offset_next = offset_reg + width_reg;
                end
            end
            dgap_pkg::BK_PACK_USE:
            begin
                payload_next = payload_reg | (rd_data_reg << offset_reg);
                idx_next     = idx_reg + CW'(1);
                offset_next  = offset_reg + width_reg;
            end
            dgap_pkg::BK_OUT:
            begin
                if (words.ready && (last_reg || err_reg))
                begin
                    count_next = '0;
                    flush_next = 1'b0;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
        if (pack_start)
        begin
            width_next   = new_width;
            nwords_next  = dgap_pkg::gaps_per_word(new_width);
            idx_next     = '0;
            offset_next  = '0;
            payload_next = '0;
        end
    end

    assign words.valid        = (state_reg == dgap_pkg::BK_OUT);
    assign words.packed_word  = word_reg;
    assign words.last_word    = last_reg;
    assign words.gap_too_wide = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dgap_pkg::BK_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            scan_max_reg   <= '0;
            scan_elems_reg <= '0;
            idx_reg        <= '0;
            flush_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            scan_max_reg   <= scan_max_next;
            scan_elems_reg <= scan_elems_next;
            idx_reg        <= idx_next;
            flush_reg      <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg   <= width_next;
        nwords_reg  <= nwords_next;
        offset_reg  <= offset_next;
        payload_reg <= payload_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
        err_reg     <= err_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gap_mem[tail_addr] <= pop_item.gap;
        end
        if (rd_en)
        begin
            rd_data_reg <= gap_mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/dgap_word_packer_encoder_core.sv @@
// Top level of the gap word packer: front end, item queue, back end.
//
//  channel | dir | payload                                  | accepted when
//  docs    | in  | doc_number[31:0], list_end               | valid && ready
//  words   | out | packed_word[31:0], last_word, gap_too_wide | valid && ready
//
// The front end takes one item per cycle while the 4-entry queue has room.
// The back end takes gaps while idle until one completes a word. A word is
// packed by a read and a use step per buffered gap it packs, a step per
// padding slot and a step to form it, then is offered until taken. The
// look-ahead rescan of the gaps left behind takes a read and a use step per
// gap, plus a read step when it ends undecided; the single-port gap buffer
// read sets these steps. At list end the padding look-ahead adds up to a step per zero slot.
// Reset is asynchronous; the buffer needs no clearing. A stalled output
// holds the back end; the front end keeps filling the queue.
module dgap_word_packer_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    dgap_in_if.sink     docs,
    dgap_out_if.source  words
);

    logic                push_valid;
    logic                push_ready;
    dgap_pkg::gap_item_t push_item;
    logic                pop_valid;
    logic                pop_ready;
    dgap_pkg::gap_item_t pop_item;

    dgap_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .docs       (docs),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dgap_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dgap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .words     (words)
    );

    // an error word is empty and closes the list
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && words.gap_too_wide |->
            words.packed_word == 32'd0 && words.last_word)
        else $error("error word not empty or not last");

    // a normal word carries one of the legal width codes
    a_width_code: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && !words.gap_too_wide |->
            (words.packed_word[3:0] == dgap_pkg::CODE_W28 ||
             words.packed_word[3:0] == 4'd1 || words.packed_word[3:0] == 4'd2 ||
             words.packed_word[3:0] == 4'd3 || words.packed_word[3:0] == 4'd4 ||
             words.packed_word[3:0] == 4'd5 || words.packed_word[3:0] == 4'd7 ||
             words.packed_word[3:0] == 4'd9 || words.packed_word[3:0] == 4'd14))
        else $error("illegal width code");

    // the queue only pops into an idle back end, never while a word waits
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        words.valid |-> !pop_ready)
        else $error("queue popped while a word waits");

endmodule
